### hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and codes of the min priority queue
// Command, status and result field widths used by the queue core.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int CMD_W    = 2;
	localparam int IN_KEY_W = 32;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 10;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

### hw/rtl/mpq_key_ram.sv
// ----------------------------------------------------------------------------
// mpq_key_ram: key store of the min priority queue
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpq_key_ram #(
	parameter int DEPTH = 1023,
	parameter int WIDTH = 32,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// min_priority_queue_core: bounded min priority queue of signed keys
// Binary heap kept in one synchronous RAM; insert sifts up, remove sifts down.
// ----------------------------------------------------------------------------
// One command is worked at a time. Clear and commands that end at once (full,
// empty) go straight to the done state; read-minimum first reads the root.
// Insert into an empty queue writes the root at once; otherwise it compares
// with one parent per heap level the key climbs. Remove reads the root, then
// the last key, and when more than one key is left it sinks the moved key,
// reading the left and, where there is one, the right child at each level.
// Command time is set by the single read port of the key RAM, one heap node
// read per cycle, and by its registered read. A finished result waits in the
// output register while the next item is accepted.
module min_priority_queue_core #(
	parameter int CAPACITY  = 1023,
	parameter int KEY_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mpq_pkg::CMD_W-1:0]         cmd,
	input  logic signed [mpq_pkg::IN_KEY_W-1:0] key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mpq_pkg::VALUE_W-1:0] value,
	output logic [mpq_pkg::STATUS_W-1:0]      status,
	output logic [mpq_pkg::COUNT_W-1:0]       count
);

	import mpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 1;
	localparam int KW = KEY_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CMP,
		S_RD_MIN,
		S_DN_ROOT,
		S_DN_LAST,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_PUT,
		S_DONE
	} state_t;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [PW-1:0]   pos_q, pos_d;
	logic [PW-1:0]   cpos_q, cpos_d;
	logic [KW-1:0]   k_q, k_d;
	logic [KW-1:0]   cdat_q, cdat_d;
	logic [KW-1:0]   res_value_q, res_value_d;
	status_t         res_status_q, res_status_d;
	logic            out_valid_q, out_valid_d;
	logic [KW-1:0]   out_value_q, out_value_d;
	status_t         out_status_q, out_status_d;
	logic [CW-1:0]   out_count_q, out_count_d;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [KW-1:0]   mem_wdata;
	logic [AW-1:0]   mem_raddr;
	logic [KW-1:0]   mem_rdata;

	logic [KW-1:0]   in_key;
	logic [PW-1:0]   cnt_ext;
	logic [PW-1:0]   left_pos, right_pos, parent_pos, grand_pos;
	logic [PW-1:0]   cand_pos, cand_left;
	logic [KW-1:0]   cand_dat;

	function automatic logic key_less(input logic [KW-1:0] a, input logic [KW-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

	mpq_key_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(KW),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_key     = KW'($unsigned(key));
	assign cnt_ext    = PW'(cnt_q);
	assign left_pos   = (pos_q << 1) | PW'(1);
	assign right_pos  = left_pos + PW'(1);
	assign parent_pos = (pos_q - PW'(1)) >> 1;
	assign grand_pos  = (parent_pos - PW'(1)) >> 1;

	always_comb begin
		if (state_q == S_DN_RIGHT && !key_less(mem_rdata, cdat_q)) begin
			cand_dat = cdat_q;
			cand_pos = cpos_q;
		end else if (state_q == S_DN_RIGHT) begin
			cand_dat = mem_rdata;
			cand_pos = cpos_q + PW'(1);
		end else begin
			cand_dat = mem_rdata;
			cand_pos = left_pos;
		end
	end

	assign cand_left = (cand_pos << 1) | PW'(1);
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		pos_d        = pos_q;
		cpos_d       = cpos_q;
		k_d          = k_q;
		cdat_d       = cdat_q;
		res_value_d  = res_value_q;
		res_status_d = res_status_q;
		out_valid_d  = out_valid_q;
		out_value_d  = out_value_q;
		out_status_d = out_status_q;
		out_count_d  = out_count_q;
		mem_we       = 1'b0;
		mem_waddr    = pos_q[AW-1:0];
		mem_wdata    = k_q;
		mem_raddr    = '0;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_value_d  = '0;
					res_status_d = ST_OK;
					case (cmd)
						CMD_INSERT: begin
							if (cnt_ext == PW'(CAPACITY)) begin
								res_status_d = ST_FULL;
								state_d      = S_DONE;
							end else begin
								k_d   = in_key;
								pos_d = cnt_ext;
								cnt_d = cnt_q + CW'(1);
								if (cnt_q == '0) begin
									mem_we    = 1'b1;
									mem_waddr = '0;
									mem_wdata = in_key;
									state_d   = S_DONE;
								end else begin
									mem_raddr = AW'((cnt_ext - PW'(1)) >> 1);
									state_d   = S_UP_CMP;
								end
							end
						end
						CMD_REMOVE, CMD_READ: begin
							if (cnt_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_DONE;
							end else begin
								state_d = (cmd == CMD_REMOVE) ? S_DN_ROOT : S_RD_MIN;
							end
						end
						default: begin
							cnt_d   = '0;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (key_less(k_q, mem_rdata)) begin
					mem_wdata = mem_rdata;
					pos_d     = parent_pos;
					if (parent_pos == '0) begin
						state_d = S_PUT;
					end else begin
						mem_raddr = grand_pos[AW-1:0];
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD_MIN: begin
				res_value_d = mem_rdata;
				state_d     = S_DONE;
			end
			S_DN_ROOT: begin
				res_value_d = mem_rdata;
				mem_raddr   = AW'(cnt_q - CW'(1));
				cnt_d       = cnt_q - CW'(1);
				state_d     = S_DN_LAST;
			end
			S_DN_LAST: begin
				k_d   = mem_rdata;
				pos_d = '0;
				if (cnt_q == '0) begin
					state_d = S_DONE;
				end else if (cnt_q == CW'(1)) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = mem_rdata;
					state_d   = S_DONE;
				end else begin
					mem_raddr = AW'(1);
					state_d   = S_DN_LEFT;
				end
			end
			S_DN_LEFT, S_DN_RIGHT: begin
				if (state_q == S_DN_LEFT && right_pos < cnt_ext) begin
					cdat_d    = mem_rdata;
					cpos_d    = left_pos;
					mem_raddr = right_pos[AW-1:0];
					state_d   = S_DN_RIGHT;
				end else if (key_less(cand_dat, k_q)) begin
					mem_we    = 1'b1;
					mem_wdata = cand_dat;
					pos_d     = cand_pos;
					if (cand_left < cnt_ext) begin
						mem_raddr = cand_left[AW-1:0];
						state_d   = S_DN_LEFT;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end
			end
			S_PUT: begin
				mem_we  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d  = 1'b1;
					out_value_d  = res_value_q;
					out_status_d = res_status_q;
					out_count_d  = cnt_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		cpos_q       <= cpos_d;
		k_q          <= k_d;
		cdat_q       <= cdat_d;
		res_value_q  <= res_value_d;
		res_status_q <= res_status_d;
		out_value_q  <= out_value_d;
		out_status_q <= out_status_d;
		out_count_q  <= out_count_d;
	end

	assign out_valid = out_valid_q;
	assign value     = $signed(VALUE_W'(out_value_q));
	assign status    = out_status_q;
	assign count     = COUNT_W'(out_count_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(cnt_q) <= PW'(CAPACITY))
		else $error("element count above capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> PW'(mem_waddr) <= cnt_ext)
		else $error("heap write beyond held keys");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (value == '0 && count == '0))
		else $error("empty result carries a key or count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_status_q == ST_FULL) |-> PW'(cnt_q) == PW'(CAPACITY))
		else $error("insert dropped below capacity");

endmodule
